// File: hw/rtl/assert_macros.svh
// assertion macros shared by the gelu rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define GELU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true out of reset
`define GELU_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: hw/rtl/gelu_pkg.sv
// gelu activation unit package: fixed-point constants, register indexes, shared types
// no dependencies
`default_nettype none

package gelu_pkg;

  // internal magnitude (q24, capped at 16.0), lookup argument and lookup result widths
  localparam int unsigned A_W = 29;
  localparam int unsigned V_W = 34;
  localparam int unsigned F_W = 31;

  // q30 constants
  localparam longint unsigned ONE_Q30        = 64'd1 << 30;
  localparam longint unsigned C_RSQRT2       = 64'd759250125;
  localparam longint unsigned C_ALPHA        = 64'd856722024;
  localparam longint unsigned C_HALF_ALPHA   = 64'd428361012;
  localparam longint unsigned C_BETA         = 64'd38308325;
  localparam longint unsigned C_GAMMA        = 64'd114924975;
  localparam longint unsigned C_TWO_RSQRT_PI = 64'd1211587905;
  localparam longint unsigned SLOPE_CAP      = 64'd1 << 32;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_APPROX_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_MODE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    TAB_ERF,
    TAB_TANH,
    TAB_EXP
  } tab_kind_e;

  typedef struct packed {
    logic approx;    // 1: tanh form
    logic gradient;  // 1: dy times derivative
  } gelu_mode_t;

endpackage

`default_nettype wire

// File: hw/rtl/gelu_if.sv
// gelu channel interfaces: sample input, result output and register write port
// depends on gelu_pkg
`default_nettype none

interface gelu_in_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x_value;
  logic signed [DATA_WIDTH-1:0] upstream_grad;
  logic                         last_element;

  modport source (output valid, x_value, upstream_grad, last_element, input ready);
  modport sink (input valid, x_value, upstream_grad, last_element, output ready);
endinterface

interface gelu_out_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_value;
  logic                         saturated;
  logic                         last_result;

  modport source (output valid, result_value, saturated, last_result, input ready);
  modport sink (input valid, result_value, saturated, last_result, output ready);
endinterface

interface gelu_cfg_if;
  import gelu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/gelu_lut.sv
// gelu interpolated table lookup, three register stages: index, table read, interpolate
// depends on gelu_pkg; table contents are built at elaboration
`default_nettype none

module gelu_lut #(
  parameter int unsigned         TABLE_ENTRIES = 256,
  parameter int unsigned         SPAN_SHIFT    = 27,
  parameter gelu_pkg::tab_kind_e KIND_A        = gelu_pkg::TAB_ERF,
  parameter gelu_pkg::tab_kind_e KIND_B        = gelu_pkg::TAB_TANH
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic                         sel_i,
  input  logic [gelu_pkg::V_W-1:0]     v_i,
  output logic [gelu_pkg::F_W-1:0]     f_o
);
  import gelu_pkg::*;

  localparam int unsigned IXW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned PSW = SPAN_SHIFT + IXW;
  localparam int unsigned MW  = F_W + SPAN_SHIFT;
  localparam logic [F_W-1:0] BEYOND = (KIND_A == TAB_EXP) ? '0 : F_W'(ONE_Q30);

  typedef logic [31:0] rom_t [0:TABLE_ENTRIES];

  // shift-subtract divide, elaboration only
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | longint'(n[i]);
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned div_small(longint unsigned x, int k);
    case (k)
      1:  return x;
      2:  return x / 2;
      3:  return x / 3;
      4:  return x / 4;
      5:  return x / 5;
      6:  return x / 6;
      7:  return x / 7;
      8:  return x / 8;
      9:  return x / 9;
      10: return x / 10;
      11: return x / 11;
      12: return x / 12;
      13: return x / 13;
      14: return x / 14;
      default: return x;
    endcase
  endfunction

  // e^-f for f in [0,1], horner series
  function automatic longint unsigned exp_part(longint unsigned f);
    longint unsigned r;
    r = ONE_Q30;
    for (int k = 14; k >= 1; k--) begin
      r = ONE_Q30 - div_small((f * r) >> 30, k);
    end
    return r;
  endfunction

  function automatic longint unsigned exp_neg(longint unsigned t);
    longint unsigned n;
    longint unsigned r;
    longint unsigned e1;
    n = t >> 24;
    if (n >= 24) return 0;
    r  = exp_part((t & 64'hFFFFFF) << 6);
    e1 = exp_part(ONE_Q30);
    for (int i = 0; i < 24; i++) begin
      if (longint'(i) < n) r = (r * e1) >> 30;
    end
    return r;
  endfunction

  function automatic longint unsigned gauss_at(longint unsigned i);
    longint unsigned w;
    w = udiv(i << 25, 64'(TABLE_ENTRIES));
    return exp_neg((w * w) >> 24);
  endfunction

  function automatic rom_t build_rom(tab_kind_e kind);
    rom_t            t;
    longint unsigned total;
    longint unsigned b;
    longint unsigned integ;
    longint unsigned e;
    longint unsigned v;
    total = 0;
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      case (kind)
        TAB_TANH: begin
          v    = udiv(64'(k) << 27, 64'(TABLE_ENTRIES));
          e    = exp_neg(2 * v);
          t[k] = 32'(udiv((ONE_Q30 - e) << 30, ONE_Q30 + e));
        end
        TAB_EXP: t[k] = 32'(exp_neg(udiv(64'(k) << 28, 64'(TABLE_ENTRIES))));
        TAB_ERF: begin
          if (k == 0) begin
            t[k] = '0;
          end else begin
            // running simpson sum on a grid four times finer than the table
            b = 4 * (64'(k) - 1);
            total += gauss_at(b) + 4 * gauss_at(b + 1) + 2 * gauss_at(b + 2)
                   + 4 * gauss_at(b + 3) + gauss_at(b + 4);
            integ = udiv(total * 2, 3 * 64'(TABLE_ENTRIES));
            e     = (integ * C_TWO_RSQRT_PI) >> 30;
            t[k]  = 32'((e > ONE_Q30) ? ONE_Q30 : e);
          end
        end
        default: t[k] = '0;
      endcase
    end
    return t;
  endfunction

  localparam rom_t ROM_A = build_rom(KIND_A);
  localparam rom_t ROM_B = build_rom(KIND_B);

  // stage 1: index and fraction
  logic [PSW-1:0]        pos;
  logic [IXW-1:0]        idx_d;
  logic [IXW-1:0]        idx_q;
  logic [SPAN_SHIFT-1:0] frac_q;
  logic                  bey_q;
  logic                  sel_q;

  always_comb begin
    pos   = PSW'(v_i[SPAN_SHIFT-1:0]) * PSW'(TABLE_ENTRIES);
    idx_d = pos[PSW-1:SPAN_SHIFT];
    if (idx_d >= IXW'(TABLE_ENTRIES)) idx_d = IXW'(TABLE_ENTRIES - 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q  <= idx_d;
      frac_q <= pos[SPAN_SHIFT-1:0];
      bey_q  <= |v_i[V_W-1:SPAN_SHIFT];
      sel_q  <= sel_i;
    end
  end

  // stage 2: neighbor reads
  logic [F_W-1:0]        lo;
  logic [F_W-1:0]        hi;
  logic [F_W-1:0]        lo_q;
  logic [F_W-1:0]        diff_q;
  logic                  up_q;
  logic [SPAN_SHIFT-1:0] frac2_q;
  logic                  bey2_q;
  logic [IXW-1:0]        idx_nxt;

  always_comb begin
    idx_nxt = idx_q + IXW'(1);
    lo      = sel_q ? ROM_B[idx_q][F_W-1:0] : ROM_A[idx_q][F_W-1:0];
    hi      = sel_q ? ROM_B[idx_nxt][F_W-1:0] : ROM_A[idx_nxt][F_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q    <= lo;
      up_q    <= (hi >= lo);
      diff_q  <= (hi >= lo) ? hi - lo : lo - hi;
      frac2_q <= frac_q;
      bey2_q  <= bey_q;
    end
  end

  // stage 3: interpolate
  logic [MW-1:0]  prod;
  logic [F_W-1:0] step;
  logic [F_W-1:0] f_q;

  always_comb begin
    prod = MW'(diff_q) * MW'(frac2_q);
    step = F_W'(prod >> SPAN_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q <= bey2_q ? BEYOND : (up_q ? lo_q + step : lo_q - step);
    end
  end

  assign f_o = f_q;

endmodule

`default_nettype wire

// File: hw/rtl/gelu_core.sv
// gelu datapath: argument scaling, two table lookups, slope, final product and saturation
// depends on gelu_pkg, gelu_lut and assert_macros.svh
`default_nettype none

module gelu_core #(
  parameter int unsigned DATA_WIDTH    = 16,
  parameter int unsigned FRAC_BITS     = 12,
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gelu_pkg::gelu_mode_t         mode_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] x_i,
  input  logic signed [DATA_WIDTH-1:0] dy_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] result_o,
  output logic                         sat_o,
  output logic                         last_o
);
  import gelu_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned NST = 13;
  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned PW  = DW + 34;
  localparam int unsigned RW  = DW + 4;

  typedef struct packed {
    logic [A_W-1:0]       a;
    logic [A_W-1:0]       ahh;
    logic [35:0]          w;
    logic                 negx;
    logic signed [DW-1:0] p;
    logic                 last;
  } side_t;

  logic           en;
  logic [NST-1:0] vld_q;

  // whole pipeline advances together unless a finished result is held
  assign en          = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // stage 1: magnitude in q24, capped at 16.0
  logic [DW-1:0]        mag;
  logic                 cap;
  logic [A_W-1:0]       a1_q;
  logic                 neg1_q;
  logic signed [DW-1:0] p1_q;
  logic                 last1_q;

  always_comb begin
    mag = x_i[DW-1] ? DW'(-x_i) : DW'(x_i);
    cap = 64'(mag) >= (64'd16 << FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q    <= cap ? A_W'(64'd1 << 28) : A_W'(64'(mag) << (24 - FRAC_BITS));
      neg1_q  <= x_i[DW-1];
      p1_q    <= mode_i.gradient ? dy_i : x_i;
      last1_q <= last_i;
    end
  end

  // stage 2: products of a
  logic [58:0]          m_rs;
  logic [57:0]          m_sq;
  logic [58:0]          m_ah;
  logic [57:0]          m_ahh;
  logic [A_W-1:0]       rs2_q;
  logic [32:0]          sq2_q;
  logic [A_W-1:0]       ah2_q;
  logic [A_W-1:0]       ahh2_q;
  logic [A_W-1:0]       a2_q;
  logic                 neg2_q;
  logic signed [DW-1:0] p2_q;
  logic                 last2_q;

  always_comb begin
    m_rs  = 59'(a1_q) * 59'(C_RSQRT2);
    m_sq  = 58'(a1_q) * 58'(a1_q);
    m_ah  = 59'(a1_q) * 59'(C_ALPHA);
    m_ahh = 58'(a1_q) * 58'(C_HALF_ALPHA);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rs2_q   <= A_W'(m_rs >> 30);
      sq2_q   <= 33'(m_sq >> 24);
      ah2_q   <= A_W'(m_ah >> 30);
      ahh2_q  <= A_W'(m_ahh >> 30);
      a2_q    <= a1_q;
      neg2_q  <= neg1_q;
      p2_q    <= p1_q;
      last2_q <= last1_q;
    end
  end

  // stage 3: cube and tanh slope polynomial
  logic [61:0]          m_cube;
  logic [59:0]          m_w;
  logic [36:0]          cube3_q;
  logic [35:0]          w3_q;
  logic [A_W-1:0]       rs3_q;
  logic [31:0]          sqh3_q;
  logic [A_W-1:0]       ah3_q;
  logic [A_W-1:0]       ahh3_q;
  logic [A_W-1:0]       a3_q;
  logic                 neg3_q;
  logic signed [DW-1:0] p3_q;
  logic                 last3_q;

  always_comb begin
    m_cube = 62'(sq2_q) * 62'(a2_q);
    m_w    = 60'(sq2_q) * 60'(C_GAMMA);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cube3_q <= 37'(m_cube >> 24);
      w3_q    <= 36'(m_w >> 24) + 36'(C_ALPHA);
      rs3_q   <= rs2_q;
      sqh3_q  <= 32'(sq2_q >> 1);
      ah3_q   <= ah2_q;
      ahh3_q  <= ahh2_q;
      a3_q    <= a2_q;
      neg3_q  <= neg2_q;
      p3_q    <= p2_q;
      last3_q <= last2_q;
    end
  end

  // stage 4: lookup arguments
  logic [62:0]    m_cb;
  logic [V_W-1:0] z;
  logic [V_W-1:0] vf4_q;
  logic [V_W-1:0] ve4_q;
  side_t          side4_q;

  always_comb begin
    m_cb = 63'(cube3_q) * 63'(C_BETA);
    z    = V_W'(ah3_q) + V_W'(m_cb >> 30);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vf4_q   <= mode_i.approx ? z : V_W'(rs3_q);
      ve4_q   <= V_W'(sqh3_q);
      side4_q <= '{a: a3_q, ahh: ahh3_q, w: w3_q, negx: neg3_q, p: p3_q, last: last3_q};
    end
  end

  // stages 5 to 7: table lookups, side data delayed alongside
  logic [F_W-1:0] f_lut;
  logic [F_W-1:0] e_lut;
  side_t          side_q [0:2];

  gelu_lut #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SPAN_SHIFT    (27),
    .KIND_A        (TAB_ERF),
    .KIND_B        (TAB_TANH)
  ) u_lut_f (
    .clk_i (clk_i),
    .en_i  (en),
    .sel_i (mode_i.approx),
    .v_i   (vf4_q),
    .f_o   (f_lut)
  );

  gelu_lut #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SPAN_SHIFT    (28),
    .KIND_A        (TAB_EXP),
    .KIND_B        (TAB_EXP)
  ) u_lut_e (
    .clk_i (clk_i),
    .en_i  (en),
    .sel_i (1'b0),
    .v_i   (ve4_q),
    .f_o   (e_lut)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side4_q;
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];
    end
  end

  // stage 8: exact slope and sech^2
  logic [57:0]    m_se;
  logic [61:0]    m_ff;
  logic [F_W-1:0] f8_q;
  logic [34:0]    se8_q;
  logic [F_W-1:0] sech8_q;
  side_t          side8_q;

  always_comb begin
    m_se = 58'(side_q[2].ahh) * 58'(e_lut);
    m_ff = 62'(f_lut) * 62'(f_lut);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f8_q    <= f_lut;
      se8_q   <= {34'(m_se >> 24), 1'b0};
      sech8_q <= F_W'(ONE_Q30) - F_W'(m_ff >> 30);
      side8_q <= side_q[2];
    end
  end

  // stage 9: a times sech^2
  logic [59:0]    m_mm;
  logic [A_W-1:0] mm9_q;
  logic [F_W-1:0] f9_q;
  logic [34:0]    se9_q;
  side_t          side9_q;

  assign m_mm = 60'(side8_q.a) * 60'(sech8_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mm9_q   <= A_W'(m_mm >> 30);
      f9_q    <= f8_q;
      se9_q   <= se8_q;
      side9_q <= side8_q;
    end
  end

  // stage 10: tanh slope and slope select
  logic [64:0]    m_st;
  logic [40:0]    slope;
  logic [40:0]    slope10_q;
  logic [F_W-1:0] f10_q;
  side_t          side10_q;

  always_comb begin
    m_st  = 65'(mm9_q) * 65'(side9_q.w);
    slope = mode_i.approx ? 41'(m_st >> 24) : 41'(se9_q);
    if (!mode_i.gradient) slope = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      slope10_q <= slope;
      f10_q     <= f9_q;
      side10_q  <= side9_q;
    end
  end

  // stage 11: cap slope, form inner factor in q31
  logic [32:0]        sc;
  logic signed [34:0] inner;
  logic signed [34:0] inner11_q;
  side_t              side11_q;

  always_comb begin
    sc    = (slope10_q > 41'(SLOPE_CAP)) ? 33'(SLOPE_CAP) : 33'(slope10_q);
    inner = side10_q.negx ? 35'(ONE_Q30) - 35'(f10_q) - 35'(sc)
                          : 35'(ONE_Q30) + 35'(f10_q) + 35'(sc);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inner11_q <= inner;
      side11_q  <= side10_q;
    end
  end

  // stage 12: magnitude product
  logic [DW-1:0] pm;
  logic [33:0]   im;
  logic [PW-1:0] prod12_q;
  logic          sgn12_q;
  logic          last12_q;

  always_comb begin
    pm = side11_q.p[DW-1] ? DW'(-side11_q.p) : DW'(side11_q.p);
    im = inner11_q[34] ? 34'(-inner11_q) : 34'(inner11_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod12_q <= PW'(pm) * PW'(im);
      sgn12_q  <= side11_q.p[DW-1] ^ inner11_q[34];
      last12_q <= side11_q.last;
    end
  end

  // stage 13: round half away from zero, saturate
  logic [RW-1:0]        rnd;
  logic signed [DW-1:0] res_d;
  logic                 sat_d;
  logic signed [DW-1:0] res_q;
  logic                 sat_q;
  logic                 last_q;

  always_comb begin
    rnd = RW'((prod12_q + (PW'(1) << 30)) >> 31);
    sat_d = 1'b0;
    if (sgn12_q) begin
      if (rnd > (RW'(1) << (DW - 1))) begin
        res_d = {1'b1, {(DW-1){1'b0}}};
        sat_d = 1'b1;
      end else begin
        res_d = DW'(-rnd);
      end
    end else begin
      if (rnd > ((RW'(1) << (DW - 1)) - RW'(1))) begin
        res_d = {1'b0, {(DW-1){1'b1}}};
        sat_d = 1'b1;
      end else begin
        res_d = DW'(rnd);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      sat_q  <= sat_d;
      last_q <= last12_q;
    end
  end

  assign result_o = res_q;
  assign sat_o    = sat_q;
  assign last_o   = last_q;

  `GELU_ASSERT(a_stall_holds_valids, !en |=> $stable(vld_q), "stage valids moved during stall")
  `GELU_ASSERT(a_sat_at_limit,
    out_valid_o && sat_o |-> (result_o == {1'b1, {(DW-1){1'b0}}}) ||
                             (result_o == {1'b0, {(DW-1){1'b1}}}),
    "saturation flag without a clipped value")
  `GELU_ASSERT_NEVER(a_slope_capped, sc > 33'(SLOPE_CAP), "slope above cap")
  `GELU_ASSERT_NEVER(a_fwd_no_slope, !mode_i.gradient && (slope != '0),
    "forward mode produced a slope term")

endmodule

`default_nettype wire

// File: hw/rtl/gelu_activation_unit.sv
// Throughput: one transaction per cycle; the 13-stage pipeline moves as a whole,
// and a result held by out_o.ready low stalls every stage in place.
// Reset: rst_ni clears all stage valid bits and sets approx_mode and gradient_mode to 0.
// Configuration writes are always accepted (cfg_i.ready stays high).
`default_nettype none

module gelu_activation_unit #(
  parameter int unsigned DATA_WIDTH    = 16,
  parameter int unsigned FRAC_BITS     = 12,
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gelu_cfg_if.sink   cfg_i,
  gelu_in_if.sink    in_i,
  gelu_out_if.source out_o
);
  import gelu_pkg::*;

  gelu_mode_t mode_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_APPROX_MODE:   mode_q.approx   <= cfg_i.data[0];
        REG_GRADIENT_MODE: mode_q.gradient <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  gelu_core #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRAC_BITS     (FRAC_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .x_i         (in_i.x_value),
    .dy_i        (in_i.upstream_grad),
    .last_i      (in_i.last_element),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (out_o.result_value),
    .sat_o       (out_o.saturated),
    .last_o      (out_o.last_result)
  );

endmodule

`default_nettype wire
